@@ hdl/sqs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqs_pkg: shared types and constants
// Item structs, opcodes, status codes and cell control for the search queue.
// ----------------------------------------------------------------------------
package sqs_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int DATA_W        = 32;
  localparam int POS_W         = 7;

  typedef enum logic [1:0] {
    MODE_ENQ    = 2'd0,
    MODE_DEQ    = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_DUMP   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_ACCEPT    = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOTFOUND  = 3'd4,
    ST_LISTED    = 3'd5
  } status_e;

  typedef struct packed {
    mode_e                     mode;
    logic signed [DATA_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  data;
    logic [POS_W-1:0]          position;
    logic                      last;
  } out_item_t;

  // per-cell load/move controls
  typedef struct packed {
    logic load;       // take the enqueued value
    logic take_next;  // take the neighbor toward the tail
    logic take_head;  // take the head (rotation wrap)
  } cell_ctrl_t;

endpackage

@@ hdl/sqs_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqs_cell: one queue slot
// Holds one entry, moves it along the chain and compares it with the key.
// ----------------------------------------------------------------------------
module sqs_cell
  import sqs_pkg::*;
(
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic signed [DATA_W-1:0] next_i,
  input  logic signed [DATA_W-1:0] head_i,
  output logic signed [DATA_W-1:0] data_o,
  output logic                     match_o
);

  logic signed [DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = value_i;
    end else if (ctrl_i.take_head) begin
      data_d = head_i;
    end else if (ctrl_i.take_next) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == value_i);

endmodule

@@ hdl/shift_queue_with_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_queue_with_search: bounded FIFO with search and dump
// Chain of DEPTH cells, head in cell 0; enqueue, dequeue, search, dump.
// ----------------------------------------------------------------------------
// Entries sit packed in a row of cells, head in cell 0. Enqueue writes the
// cell at the fill count, dequeue hands every entry one cell toward the head.
// Enqueue, dequeue, a search with no hit and any operation on an empty queue
// each give a single result. A search with hits and a dump go on from the
// accept into a walk: the occupied part of the chain rotates one place per
// cycle unless paused (head wraps to the tail slot), so each entry passes
// cell 0 once and the queue ends in its original order. The walk pauses
// only when a result is due and the output register is held by out_stall_i.
// Search hits are found by per-cell comparators at accept time; the hit
// mask shifts along with the rotation, which tells the walk which hit is
// the final one.
// A new item is taken only while the walk is idle and the output register can
// take a result. Entries have no reset; only occupied cells are ever read.
// ----------------------------------------------------------------------------
module shift_queue_with_search
  import sqs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int CW = $clog2(DEPTH + 1);  // fill count
  localparam int SW = $clog2(DEPTH);      // walk step

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] step_q, step_d;
  logic [DEPTH-1:0] mask_q, mask_d;
  logic is_search_q, is_search_d;
  logic out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0] cell_match;
  logic [DEPTH-1:0] occ_vec;
  logic [DEPTH-1:0] mask_new;
  cell_ctrl_t cell_ctrl [DEPTH];

  logic in_fire, out_free, full, empty;
  logic enq_do, deq_do, rot_do;
  logic [CW-1:0] cnt_m1;
  logic [POS_W-1:0] pos_cur;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_fire = in_valid_i && !in_stall_o;

  assign full   = (cnt_q == CW'(DEPTH));
  assign empty  = (cnt_q == '0);
  assign cnt_m1 = cnt_q - CW'(1);
  assign pos_cur = {{(POS_W - SW){1'b0}}, step_q} + POS_W'(1);

  // chain of cells; the last cell feeds itself as its tail neighbor
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] nb;
    if (g == DEPTH - 1) begin : g_tail
      assign nb = cell_data[g];
    end else begin : g_mid
      assign nb = cell_data[g + 1];
    end
    sqs_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[g]),
      .value_i (in_item_i.value),
      .next_i  (nb),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[g]),
      .match_o (cell_match[g])
    );
    assign occ_vec[g] = (CW'(g) < cnt_q);
  end

  // search keeps only hits; dump walks every occupied slot
  assign mask_new = (in_item_i.mode == MODE_SEARCH) ? (cell_match & occ_vec) : occ_vec;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[i].load      = enq_do && (CW'(i) == cnt_q);
      cell_ctrl[i].take_next = deq_do || (rot_do && (CW'(i) < cnt_m1));
      cell_ctrl[i].take_head = rot_do && (CW'(i) == cnt_m1);
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    step_d      = step_q;
    mask_d      = mask_q;
    is_search_d = is_search_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    enq_do      = 1'b0;
    deq_do      = 1'b0;
    rot_do      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_d.data     = '0;
          out_d.position = '0;
          out_d.last     = 1'b1;
          case (in_item_i.mode)
            MODE_ENQ: begin
              out_valid_d = 1'b1;
              if (full) begin
                out_d.status = ST_OVERFLOW;
              end else begin
                out_d.status = ST_ACCEPT;
                enq_do       = 1'b1;
                cnt_d        = cnt_q + CW'(1);
              end
            end
            MODE_DEQ: begin
              out_valid_d = 1'b1;
              if (empty) begin
                out_d.status = ST_UNDERFLOW;
              end else begin
                out_d.status = ST_ACCEPT;
                out_d.data   = cell_data[0];
                deq_do       = 1'b1;
                cnt_d        = cnt_m1;
              end
            end
            default: begin
              if (mask_new == '0) begin
                out_valid_d  = 1'b1;
                out_d.status = (in_item_i.mode == MODE_SEARCH) ? ST_NOTFOUND
                                                               : ST_UNDERFLOW;
              end else begin
                mask_d      = mask_new;
                step_d      = '0;
                is_search_d = (in_item_i.mode == MODE_SEARCH);
                state_d     = S_WALK;
              end
            end
          endcase
        end
      end
      S_WALK: begin
        // hold the rotation while a due result cannot be stored
        if (!mask_q[0] || out_free) begin
          rot_do = 1'b1;
          mask_d = mask_q >> 1;
          step_d = step_q + SW'(1);
          if (mask_q[0]) begin
            out_valid_d    = 1'b1;
            out_d.status   = is_search_q ? ST_FOUND : ST_LISTED;
            out_d.data     = cell_data[0];
            out_d.position = pos_cur;
            out_d.last     = (mask_q[DEPTH-1:1] == '0);
          end
          if (step_q == cnt_m1[SW-1:0]) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      step_q      <= '0;
      mask_q      <= '0;
      is_search_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      mask_q      <= mask_d;
      is_search_q <= is_search_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ hdl/sqs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqs_checker: port-level checks for the search queue
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module sqs_checker
  import sqs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // no item is taken while the output register is blocked
  a_no_accept_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !(in_valid_i && !in_stall_o))
    else $error("item accepted with blocked output");

  // walk results carry a slot, single results do not
  a_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (((out_item_o.status == ST_FOUND) || (out_item_o.status == ST_LISTED))
                     == (out_item_o.position != '0)))
    else $error("position does not fit status");

  // single-result statuses always close their item
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_item_o.status == ST_ACCEPT) || (out_item_o.status == ST_OVERFLOW) ||
                    (out_item_o.status == ST_UNDERFLOW) || (out_item_o.status == ST_NOTFOUND))
    |-> out_item_o.last)
    else $error("single result without last");

endmodule

bind shift_queue_with_search sqs_checker u_sqs_checker (.*);
